>>> hdl/abtlp_pkg.sv
`timescale 1ns / 1ps

package abtlp_pkg;

  // Output buffer depth; the usable capacity is capped by the 16-bit write address
  localparam int OUT_DEPTH = 65536;
  localparam int CAP_INT   = (OUT_DEPTH < 65536) ? OUT_DEPTH : 65536;
  localparam logic [16:0] CAP = 17'(CAP_INT);

  // Register reset and header size limits
  localparam logic [2:0] LEN_SIZE_RESET = 3'd4;
  localparam logic [2:0] HDR_MIN        = 3'd1;
  localparam logic [2:0] HDR_MAX        = 3'd4;

  // Byte values of interest
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;

  // Zero-run counter saturates here; two zeros arm a start code
  localparam logic [1:0] ZRUN_ARMED = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  // Everything one input beat produces, handed from the parser to the emitter
  typedef struct packed {
    logic        pay_vld;
    logic [15:0] pay_addr;
    logic [7:0]  pay_data;
    logic [2:0]  hdr_cnt;    // header bytes kept (inside the buffer)
    logic [15:0] hdr_base;
    logic [2:0]  hdr_size;   // full header size, sets byte order
    logic [16:0] hdr_len;
    logic        done_vld;
    logic [16:0] total;
    logic        len_flag;
    logic        overrun;
  } desc_t;

endpackage

>>> hdl/abtlp_in_if.sv
`timescale 1ns / 1ps

interface abtlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_packet;

  modport source (output valid, output in_byte, output end_of_packet, input ready);
  modport sink   (input valid, input in_byte, input end_of_packet, output ready);
endinterface

>>> hdl/abtlp_out_if.sv
`timescale 1ns / 1ps

interface abtlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] wr_addr;
  logic [7:0]  wr_data;
  logic [16:0] out_length;
  logic        len_too_big;
  logic        buf_overrun;
  logic        last;

  modport source (
    output valid, output kind, output wr_addr, output wr_data, output out_length,
    output len_too_big, output buf_overrun, output last, input ready
  );
  modport sink (
    input valid, input kind, input wr_addr, input wr_data, input out_length,
    input len_too_big, input buf_overrun, input last, output ready
  );
endinterface

>>> hdl/abtlp_cfg_if.sv
`timescale 1ns / 1ps

interface abtlp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] prefix_bytes;

  modport source (output valid, output prefix_bytes, input ready);
  modport sink   (input valid, input prefix_bytes, output ready);
endinterface

>>> hdl/annexb_to_length_prefixed.sv
`timescale 1ns / 1ps
// An accepted beat is held in the work register, its results then in the output register.
// Throughput: 1 input beat per cycle while each beat causes at most one result and out_ch
// is not stalled; a beat causing more (payload, up to 4 header bytes, done) holds the input
// until its last result is taken; the single output register carries one result per cycle.
// Reset (rst, synchronous): clears packet state and pending results, prefix size returns to 4.

module annexb_to_length_prefixed
  import abtlp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  abtlp_in_if.sink      in_ch,
  abtlp_cfg_if.sink     cfg,
  abtlp_out_if.source   out_ch
);

  logic  load;
  logic  take_ok;
  desc_t desc;

  // Start-code parsing and unit bookkeeping
  abtlp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .take_ok (take_ok),
    .load    (load),
    .desc    (desc)
  );

  // Result sequencing into the output register
  abtlp_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .desc    (desc),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

>>> hdl/abtlp_parse.sv
`timescale 1ns / 1ps

module abtlp_parse
  import abtlp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  abtlp_in_if.sink       in_ch,
  abtlp_cfg_if.sink      cfg,
  input  logic           take_ok,
  output logic           load,
  output desc_t          desc
);

  // Packet state
  logic [2:0]  prefix_bytes;
  logic        in_unit;
  logic [1:0]  zero_run;
  logic [16:0] header_addr;
  logic [16:0] write_ptr;
  logic [16:0] commit_end;
  logic        len_flag;
  logic        overrun_flag;
  logic [2:0]  hdr_size;

  logic [7:0]  b;
  logic        eop;
  logic        start;
  logic [2:0]  eff;
  logic        wp_room;
  logic        pay_ok;
  logic [16:0] wp_inc;
  logic [16:0] wp_mid;
  logic [16:0] ce_mid;
  logic        of_mid;
  logic [1:0]  zr_mid;
  logic [16:0] c_ce;
  logic        c_do;
  logic [16:0] pstart;
  logic [16:0] len;
  logic        lf_close;
  logic [16:0] space;
  logic [2:0]  kept;
  logic        of_close;
  logic [16:0] ha_close;
  logic [16:0] open_end;
  logic [16:0] wp_open;
  logic        lf_done;
  logic        of_done;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = take_ok;
  assign load        = in_ch.valid && take_ok;

  assign b     = in_ch.in_byte;
  assign eop   = in_ch.end_of_packet;
  assign start = (b == BYTE_START) && (zero_run == ZRUN_ARMED);

  // Header size for a unit that opens now; out-of-range codes clamp
  always_comb begin
    case (prefix_bytes)
      3'd0:    eff = HDR_MIN;
      3'd1, 3'd2, 3'd3, 3'd4: eff = prefix_bytes;
      default: eff = HDR_MAX;
    endcase
  end

  // Ordinary byte: speculative payload write, saturating pointers
  assign wp_room = write_ptr < CAP;
  assign pay_ok  = in_unit && wp_room;
  assign wp_inc  = write_ptr + 17'd1;
  assign wp_mid  = pay_ok ? wp_inc : write_ptr;
  always_comb begin
    if (pay_ok) begin
      ce_mid = (b != BYTE_ZERO) ? wp_inc : commit_end;
    end else if (in_unit && (b != BYTE_ZERO)) begin
      ce_mid = CAP;
    end else begin
      ce_mid = commit_end;
    end
  end
  assign of_mid = in_unit && !wp_room && (b != BYTE_ZERO);
  assign zr_mid = (b != BYTE_ZERO) ? 2'd0 :
                  (zero_run == ZRUN_ARMED) ? ZRUN_ARMED : zero_run + 2'd1;

  // Unit close: on a start code from the stored end, at packet end from the updated end
  assign c_ce = start ? commit_end : ce_mid;
  assign c_do = (start || eop) && in_unit && (c_ce > header_addr);

  assign pstart = header_addr + {14'd0, hdr_size};
  assign len    = (c_ce > pstart) ? c_ce - pstart : 17'd0;
  always_comb begin
    case (hdr_size)
      3'd1:    lf_close = |len[16:8];
      3'd2:    lf_close = len[16];
      default: lf_close = 1'b0;
    endcase
  end

  // Header bytes that land inside the buffer form a prefix
  assign space    = CAP - header_addr;
  assign kept     = (space >= {14'd0, hdr_size}) ? hdr_size : space[2:0];
  assign of_close = kept != hdr_size;
  assign ha_close = c_do ? c_ce : header_addr;

  // Unit open after a start code
  assign open_end = ha_close + {14'd0, eff};
  assign wp_open  = (open_end < CAP) ? open_end : CAP;

  assign lf_done = len_flag || (c_do && lf_close);
  assign of_done = overrun_flag || (!start && of_mid) || (c_do && of_close);

  // Results of this beat
  always_comb begin
    desc.pay_vld  = !start && pay_ok;
    desc.pay_addr = write_ptr[15:0];
    desc.pay_data = b;
    desc.hdr_cnt  = c_do ? kept : 3'd0;
    desc.hdr_base = header_addr[15:0];
    desc.hdr_size = hdr_size;
    desc.hdr_len  = len;
    desc.done_vld = eop;
    desc.total    = ha_close;
    desc.len_flag = lf_done;
    desc.overrun  = of_done;
  end

  // State update on each accepted beat and on each configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes <= LEN_SIZE_RESET;
      hdr_size     <= LEN_SIZE_RESET;
      in_unit      <= 1'b0;
      zero_run     <= 2'd0;
      header_addr  <= 17'd0;
      write_ptr    <= 17'd0;
      commit_end   <= 17'd0;
      len_flag     <= 1'b0;
      overrun_flag <= 1'b0;
    end else begin
      if (cfg.valid) begin
        prefix_bytes <= cfg.prefix_bytes;
      end
      if (load) begin
        if (start) begin
          hdr_size <= eff;
        end
        if (eop) begin
          in_unit      <= 1'b0;
          zero_run     <= 2'd0;
          header_addr  <= 17'd0;
          write_ptr    <= 17'd0;
          commit_end   <= 17'd0;
          len_flag     <= 1'b0;
          overrun_flag <= 1'b0;
        end else if (start) begin
          in_unit      <= 1'b1;
          zero_run     <= 2'd0;
          header_addr  <= ha_close;
          write_ptr    <= wp_open;
          commit_end   <= ha_close;
          len_flag     <= lf_done;
          overrun_flag <= of_done;
        end else begin
          zero_run     <= zr_mid;
          write_ptr    <= wp_mid;
          commit_end   <= ce_mid;
          overrun_flag <= of_done;
        end
      end
    end
  end

endmodule

>>> hdl/abtlp_emit.sv
`timescale 1ns / 1ps

module abtlp_emit
  import abtlp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  desc_t          desc,
  output logic           take_ok,
  abtlp_out_if.source    out_ch
);

  desc_t       work;
  logic [2:0]  hdr_idx;

  logic [2:0]  hdr_left;
  logic [2:0]  remain;
  logic        busy;
  logic        out_free;
  logic        take;
  logic [2:0]  pos;
  logic [31:0] len32;
  logic [1:0]  kind_next;
  logic [15:0] addr_next;
  logic [7:0]  data_next;

  assign hdr_left = work.hdr_cnt - hdr_idx;
  assign remain   = {2'd0, work.pay_vld} + hdr_left + {2'd0, work.done_vld};
  assign busy     = remain != 3'd0;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign take     = busy && out_free;
  assign take_ok  = !busy || (take && (remain == 3'd1));

  // Pick the next result: payload, then header bytes big-endian, then done
  assign pos   = work.hdr_size - 3'd1 - hdr_idx;
  assign len32 = {15'd0, work.hdr_len};
  always_comb begin
    if (work.pay_vld) begin
      kind_next = KIND_PAYLOAD;
      addr_next = work.pay_addr;
      data_next = work.pay_data;
    end else if (hdr_left != 3'd0) begin
      kind_next = KIND_HEADER;
      addr_next = work.hdr_base + {13'd0, hdr_idx};
      data_next = len32[{pos[1:0], 3'b000} +: 8];
    end else begin
      kind_next = KIND_DONE;
      addr_next = 16'd0;
      data_next = 8'd0;
    end
  end

  // Work register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      work         <= '0;
      hdr_idx      <= 3'd0;
      out_ch.valid <= 1'b0;
    end else begin
      if (load) begin
        work    <= desc;
        hdr_idx <= 3'd0;
      end else if (take) begin
        if (work.pay_vld) begin
          work.pay_vld <= 1'b0;
        end else if (hdr_left != 3'd0) begin
          hdr_idx <= hdr_idx + 3'd1;
        end else begin
          work.done_vld <= 1'b0;
        end
      end
      if (take) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.kind        <= kind_next;
      out_ch.wr_addr     <= addr_next;
      out_ch.wr_data     <= data_next;
      out_ch.out_length  <= (kind_next == KIND_DONE) ? work.total : 17'd0;
      out_ch.len_too_big <= (kind_next == KIND_DONE) && work.len_flag;
      out_ch.buf_overrun <= (kind_next == KIND_DONE) && work.overrun;
      out_ch.last        <= remain == 3'd1;
    end
  end

endmodule

>>> verif/annexb_to_length_prefixed_tb.sv
`timescale 1ns / 1ps

module annexb_to_length_prefixed_tb;
  import abtlp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int TOTAL_BEATS = 100;

  // Idle modes for either side
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_FULL   = 1;
  localparam int IDLE_SPARSE = 2;

  // One output beat
  typedef struct packed {
    kind_t       kind;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    logic [16:0] out_length;
    logic        len_too_big;
    logic        buf_overrun;
    logic        last;
  } write_t;

  // Tracks unit framing and predicts the buffer writes of each input beat
  class prefix_write_board;
    logic [2:0]  prefix_bytes = LEN_SIZE_RESET;
    int unsigned hdr_size = 4;
    bit          in_unit;
    int unsigned zero_run;
    int unsigned header_addr;
    int unsigned write_ptr;
    int unsigned commit_end;
    bit          len_flag;
    bit          overrun_flag;
    write_t      beat_writes[$];
    write_t      expected_writes[$];
    int          mismatches;
    int          checked;

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    function void add(kind_t k, int unsigned addr, int unsigned data, int unsigned total,
                      bit lf, bit of);
      write_t w;
      w.kind        = k;
      w.wr_addr     = addr[15:0];
      w.wr_data     = data[7:0];
      w.out_length  = total[16:0];
      w.len_too_big = lf;
      w.buf_overrun = of;
      w.last        = 1'b0;
      beat_writes = {beat_writes, w};
    endfunction

    function void clear_packet();
      in_unit      = 0;
      zero_run     = 0;
      header_addr  = 0;
      write_ptr    = 0;
      commit_end   = 0;
      len_flag     = 0;
      overrun_flag = 0;
    endfunction

    // Patch the big-endian length into the open unit's header
    function void close_nal();
      int unsigned pstart;
      int unsigned len;
      int unsigned addr;
      if (commit_end <= header_addr) return;
      pstart = header_addr + hdr_size;
      len = (commit_end > pstart) ? commit_end - pstart : 0;
      if (hdr_size < 4 && (len >> (8 * hdr_size)) != 0) len_flag = 1;
      for (int unsigned i = 0; i < hdr_size; i++) begin
        addr = header_addr + i;
        if (addr < CAP_INT)
          add(KIND_HEADER, addr, (len >> (8 * (hdr_size - 1 - i))) & 8'hFF, 0, 0, 0);
        else
          overrun_flag = 1;
      end
      header_addr = commit_end;
    endfunction

    // Header size is latched here; 0 behaves as 1, 5..7 as 4
    function void open_nal();
      int unsigned p;
      if (prefix_bytes < HDR_MIN) hdr_size = HDR_MIN;
      else if (prefix_bytes > HDR_MAX) hdr_size = HDR_MAX;
      else hdr_size = prefix_bytes;
      p = header_addr + hdr_size;
      commit_end = header_addr;
      write_ptr = (p < CAP_INT) ? p : CAP_INT;
      in_unit = 1;
    endfunction

    // Accepted input beat; returns how many writes it causes
    function int note_byte(logic [7:0] b, logic eop);
      write_t      w;
      int unsigned total;
      beat_writes.delete();
      if (b == BYTE_START && zero_run >= ZRUN_ARMED) begin
        if (in_unit) close_nal();
        open_nal();
        zero_run = 0;
      end else begin
        if (in_unit) begin
          if (write_ptr < CAP_INT) begin
            add(KIND_PAYLOAD, write_ptr, b, 0, 0, 0);
            write_ptr++;
            if (b != BYTE_ZERO) commit_end = write_ptr;
          end else if (b != BYTE_ZERO) begin
            overrun_flag = 1;
            commit_end = CAP_INT;
          end
        end
        if (b == BYTE_ZERO) zero_run = (zero_run < ZRUN_ARMED) ? zero_run + 1 : ZRUN_ARMED;
        else zero_run = 0;
      end
      if (eop) begin
        total = 0;
        if (in_unit) begin
          close_nal();
          total = header_addr;
        end
        add(KIND_DONE, 0, 0, total, len_flag, overrun_flag);
        clear_packet();
      end
      if (beat_writes.size() > 0) begin
        w = beat_writes[beat_writes.size() - 1];
        w.last = 1'b1;
        beat_writes[beat_writes.size() - 1] = w;
      end
      expected_writes = {expected_writes, beat_writes};
      return beat_writes.size();
    endfunction

    task cmp(string field, logic [16:0] got, logic [16:0] want);
      if (got !== want)
        flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h (beat %0d)", field, got, want,
                                checked));
    endtask

    task check_write(write_t got);
      write_t want;
      if (expected_writes.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d addr 0x%0h", got.kind,
                                got.wr_addr));
        return;
      end
      want = expected_writes.pop_front();
      cmp("kind", 17'(got.kind), 17'(want.kind));
      cmp("wr_addr", 17'(got.wr_addr), 17'(want.wr_addr));
      cmp("wr_data", 17'(got.wr_data), 17'(want.wr_data));
      cmp("out_length", got.out_length, want.out_length);
      cmp("len_too_big", 17'(got.len_too_big), 17'(want.len_too_big));
      cmp("buf_overrun", 17'(got.buf_overrun), 17'(want.buf_overrun));
      cmp("last", 17'(got.last), 17'(want.last));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;

  abtlp_in_if  in_ch ();
  abtlp_cfg_if cfg_ch ();
  abtlp_out_if out_ch ();

  annexb_to_length_prefixed u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg_ch),
    .out_ch (out_ch)
  );

  prefix_write_board sb;
  write_t seen;
  int src_mode;
  int snk_mode;
  int sink_hold;
  int sent_beats;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("annexb_to_length_prefixed test failed");
    $finish;
  end

  function automatic int draw_gap(int mode);
    case (mode)
      IDLE_FULL:   return $urandom_range(0, 9);
      IDLE_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 9) : 0;
      default:     return 0;
    endcase
  endfunction

  // Biased toward zeros and start bytes so start codes form often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return BYTE_ZERO;
    if (r == 3) return BYTE_START;
    if (r == 4) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Output side: random stalls plus an occasional long hold-off
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = draw_gap(snk_mode) + sink_hold;
      sink_hold = 0;
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Check every accepted output beat
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.kind        = kind_t'(out_ch.kind);
      seen.wr_addr     = out_ch.wr_addr;
      seen.wr_data     = out_ch.wr_data;
      seen.out_length  = out_ch.out_length;
      seen.len_too_big = out_ch.len_too_big;
      seen.buf_overrun = out_ch.buf_overrun;
      seen.last        = out_ch.last;
      sb.check_write(seen);
    end
  end

  // One input beat
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_packet <= eop;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    void'(sb.note_byte(b, eop));
    sent_beats++;
  endtask

  // Send a byte run; end_of_packet on the last byte when close is set
  task automatic send_bytes(input logic [7:0] q[$], input bit close);
    foreach (q[i]) send_byte(q[i], close && (i == q.size() - 1));
  endtask

  // Stop offering and wait until every predicted write has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_writes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_prefix_bytes(input logic [2:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.prefix_bytes <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.prefix_bytes = v;
  endtask

  // Mostly well-formed packets; some pure noise, some cut short
  task automatic build_random_packet(output logic [7:0] q[$]);
    int style;
    q.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 12)) q = {q, pick_byte()};
    end else begin
      repeat ($urandom_range(0, 2)) q = {q, pick_byte()};
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1)) q = {q, BYTE_ZERO};
        q = {q, BYTE_ZERO, BYTE_ZERO, BYTE_START};
        repeat ($urandom_range(0, 10)) q = {q, pick_byte()};
        repeat ($urandom_range(0, 2)) q = {q, BYTE_ZERO};
      end
      if (style == 1)
        while (q.size() > 1 && $urandom_range(0, 3) != 0) void'(q.pop_back());
    end
  endtask

  initial begin
    logic [7:0] q[$];
    logic [2:0] cfg_plan[5];
    int pkts;
    int plan_idx;
    sb = new;
    cfg_plan = '{3'd0, 3'd7, 3'd2, 3'd3, 3'd5};
    src_mode = IDLE_FULL;
    snk_mode = IDLE_FULL;
    sink_hold = 0;
    sent_beats = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.end_of_packet <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.prefix_bytes <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Junk before the first start code, both start code forms, trailing
    // zero, an empty unit and a packet ending on a start code
    q = '{8'h55, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h80,
          8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    send_bytes(q, 1);
    // Packet with no start code at all
    q = '{8'h7F};
    send_bytes(q, 1);
    // Size change while a unit is open applies from the next unit on;
    // packet then ends on a trailing zero
    q = '{8'h00, 8'h00, 8'h01, 8'hAA};
    send_bytes(q, 0);
    write_prefix_bytes(3'd2);
    q = '{8'hBB, 8'h00, 8'h00, 8'h01, 8'hCC, 8'h00};
    send_bytes(q, 1);

    // One-byte prefix; the sink holds off at the start so the input backs up
    write_prefix_bytes(3'd1);
    src_mode = IDLE_NONE;
    sink_hold = 300;
    q = '{8'h00, 8'h00, 8'h01};
    repeat (20) q = {q, 8'($urandom_range(1, 255))};
    q = {q, BYTE_ZERO, BYTE_ZERO, BYTE_START, 8'h02};
    send_bytes(q, 1);

    // Random packets, size register changed every other packet
    pkts = 0;
    plan_idx = 0;
    while (sent_beats < TOTAL_BEATS) begin
      if (pkts % 2 == 1) begin
        write_prefix_bytes(plan_idx < 5 ? cfg_plan[plan_idx] : 3'($urandom_range(0, 7)));
        plan_idx++;
      end
      src_mode = $urandom_range(0, 2);
      snk_mode = $urandom_range(0, 2);
      build_random_packet(q);
      send_bytes(q, 1);
      pkts++;
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("annexb_to_length_prefixed test passed");
    end else begin
      $display("annexb_to_length_prefixed test failed");
    end
    $finish;
  end

endmodule
